>>> rtl/qstg_pkg.sv
package qstg_pkg;

  // Default number of queued tones.
  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  // Audio sample rate in hertz and the length of the amplitude ramp in samples.
  localparam int unsigned SAMPLE_RATE = 22050;
  localparam int unsigned RAMP_LEN    = SAMPLE_RATE * 2 / 1000;

  // Field and state widths.
  localparam int REQ_W    = 2;
  localparam int FREQ_W   = 16;
  localparam int DUR_W    = 16;
  localparam int LEN_W    = 21;
  localparam int STEP_W   = 32;
  localparam int PHASE_W  = 32;
  localparam int PEAK_W   = 15;
  localparam int SAMPLE_W = 16;
  localparam int RAMP_W   = 6;

  localparam logic [PEAK_W-1:0] PEAK_RESET = 15'd3800;

  // Tone length: ceil(SAMPLE_RATE * 2^24 / 1000) as a reciprocal; the product
  // with the duration in ms, shifted down by 24, is the exact floor quotient.
  localparam int LEN_SHIFT    = 24;
  localparam int LEN_RECIP_W  = 29;
  localparam int LEN_PROD_W   = DUR_W + LEN_RECIP_W;
  localparam logic [63:0] LEN_RECIP =
    ((64'(SAMPLE_RATE) << LEN_SHIFT) + 64'd999) / 64'd1000;

  // Phase step: floor(rem * 2^32 / SAMPLE_RATE) with rem = freq mod SAMPLE_RATE,
  // formed as rem * ceil(2^61 / SAMPLE_RATE) shifted down by 29.
  localparam int STEP_REM_W   = 15;
  localparam int STEP_SPLIT   = 24;
  localparam int STEP_RECIP_W = 47;
  localparam int STEP_HI_W    = STEP_REM_W + STEP_RECIP_W - STEP_SPLIT;
  localparam int STEP_LO_W    = STEP_REM_W + STEP_SPLIT;
  localparam int STEP_SUM_W   = STEP_REM_W + STEP_RECIP_W;
  localparam int STEP_SHIFT   = 29;
  localparam logic [63:0] STEP_RECIP =
    ((64'd1 << 61) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);

  // Amplitude: floor(peak * ramp / RAMP_LEN) as peak * (ramp * recip) >> 28.
  localparam int GAIN_SHIFT  = 28;
  localparam int GAIN_W      = 29;
  localparam int AMP_PROD_W  = PEAK_W + GAIN_W;
  localparam logic [63:0] RAMP_RECIP =
    ((64'd1 << GAIN_SHIFT) + 64'(RAMP_LEN) - 64'd1) / 64'(RAMP_LEN);

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_QUEUE = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_TICK  = 2'd2
  } req_t;

  // Request after the length and step products.
  typedef struct packed {
    logic [REQ_W-1:0]     req;
    logic [LEN_W-1:0]     len;
    logic [STEP_HI_W-1:0] step_hi;
    logic [STEP_LO_W-1:0] step_lo;
    logic                 tone_on;
  } prep_t;

  // One queued or active tone.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [STEP_W-1:0] step;
    logic              tone_on;
  } tone_t;

  // Per-request result before amplitude scaling.
  typedef struct packed {
    logic [RAMP_W-1:0] ramp;
    logic              negative;
    logic              playing;
    logic              dropped;
  } shape_t;

  // Ramp position times the amplitude reciprocal.
  function automatic logic [GAIN_W-1:0] ramp_gain(input logic [RAMP_W-1:0] ramp);
    return GAIN_W'(ramp) * GAIN_W'(RAMP_RECIP);
  endfunction

endpackage

>>> rtl/qstg_prep.sv
module qstg_prep (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [qstg_pkg::REQ_W-1:0]  in_req,
  input  logic [qstg_pkg::FREQ_W-1:0] in_freq,
  input  logic [qstg_pkg::DUR_W-1:0]  in_dur,
  output logic                        out_valid,
  input  logic                        out_ready,
  output qstg_pkg::prep_t             out_item
);

  logic                        a_valid_r;
  logic [qstg_pkg::REQ_W-1:0]  a_req_r;
  logic [qstg_pkg::FREQ_W-1:0] a_freq_r;
  logic [qstg_pkg::DUR_W-1:0]  a_dur_r;
  logic                        b_valid_r;
  qstg_pkg::prep_t             b_item_r;
  qstg_pkg::prep_t             b_item_nxt;
  logic                        a_ready;
  logic                        b_ready;
  logic [qstg_pkg::STEP_REM_W-1:0] freq_rem;
  logic [qstg_pkg::LEN_PROD_W-1:0] len_prod;

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  // Frequency modulo the sample rate; whole turns of the phase drop out.
  always_comb begin
    if (a_freq_r >= qstg_pkg::FREQ_W'(2 * qstg_pkg::SAMPLE_RATE)) begin
      freq_rem = qstg_pkg::STEP_REM_W'(a_freq_r - qstg_pkg::FREQ_W'(2 * qstg_pkg::SAMPLE_RATE));
    end else if (a_freq_r >= qstg_pkg::FREQ_W'(qstg_pkg::SAMPLE_RATE)) begin
      freq_rem = qstg_pkg::STEP_REM_W'(a_freq_r - qstg_pkg::FREQ_W'(qstg_pkg::SAMPLE_RATE));
    end else begin
      freq_rem = qstg_pkg::STEP_REM_W'(a_freq_r);
    end
  end

  // Tone length in samples and the two partial products of the phase step.
  always_comb begin
    len_prod = qstg_pkg::LEN_PROD_W'(a_dur_r) * qstg_pkg::LEN_PROD_W'(qstg_pkg::LEN_RECIP);
    b_item_nxt.req = a_req_r;
    if (a_dur_r == '0) begin
      b_item_nxt.len = qstg_pkg::LEN_W'(1);
    end else begin
      b_item_nxt.len = len_prod[qstg_pkg::LEN_SHIFT +: qstg_pkg::LEN_W];
    end
    b_item_nxt.step_hi = qstg_pkg::STEP_HI_W'(freq_rem)
      * qstg_pkg::STEP_HI_W'(qstg_pkg::STEP_RECIP >> qstg_pkg::STEP_SPLIT);
    b_item_nxt.step_lo = qstg_pkg::STEP_LO_W'(freq_rem)
      * qstg_pkg::STEP_LO_W'(qstg_pkg::STEP_RECIP[qstg_pkg::STEP_SPLIT-1:0]);
    b_item_nxt.tone_on = (a_freq_r != '0);
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_req_r  <= in_req;
      a_freq_r <= in_freq;
      a_dur_r  <= in_dur;
    end
    if (b_ready && a_valid_r) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_item  = b_item_r;

endmodule

>>> rtl/qstg_player.sv
module qstg_player #(
  parameter int unsigned QUEUE_DEPTH = qstg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qstg_pkg::prep_t  in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output qstg_pkg::shape_t out_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Tone queue storage with a registered read port.
  qstg_pkg::tone_t mem [QUEUE_DEPTH];
  qstg_pkg::tone_t rd_q_r;
  qstg_pkg::tone_t byp_data_r;
  logic            byp_r;

  logic                         c_valid_r;
  qstg_pkg::shape_t             c_item_r;
  qstg_pkg::shape_t             c_item_nxt;
  logic [CNT_W-1:0]             count_r,   count_nxt;
  logic [PTR_W-1:0]             wr_ptr_r,  wr_ptr_nxt;
  logic [PTR_W-1:0]             rd_ptr_r,  rd_ptr_nxt;
  logic [qstg_pkg::LEN_W-1:0]   left_r,    left_nxt;
  logic [qstg_pkg::LEN_W-1:0]   total_r,   total_nxt;
  logic [qstg_pkg::STEP_W-1:0]  step_r,    step_nxt;
  logic                         tone_on_r, tone_on_nxt;
  logic [qstg_pkg::PHASE_W-1:0] phase_r,   phase_nxt;

  logic                           advance;
  logic                           wr_en;
  logic [qstg_pkg::STEP_SUM_W-1:0] step_sum;
  qstg_pkg::tone_t                new_entry;
  qstg_pkg::tone_t                head;
  logic                           load;
  logic [qstg_pkg::LEN_W-1:0]     cur_left;
  logic [qstg_pkg::LEN_W-1:0]     cur_total;
  logic [qstg_pkg::STEP_W-1:0]    cur_step;
  logic                           cur_on;
  logic [qstg_pkg::PHASE_W-1:0]   cur_phase;
  logic [qstg_pkg::PHASE_W-1:0]   phase_sum;
  logic [qstg_pkg::LEN_W-1:0]     played;
  logic [qstg_pkg::LEN_W-1:0]     edge_dist;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign in_ready = !c_valid_r || out_ready;
  assign advance  = in_valid && in_ready;

  // Final phase step from the two partial products.
  assign step_sum = {in_item.step_hi, {qstg_pkg::STEP_SPLIT{1'b0}}}
                  + qstg_pkg::STEP_SUM_W'(in_item.step_lo);
  assign new_entry.len     = in_item.len;
  assign new_entry.step    = step_sum[qstg_pkg::STEP_SHIFT +: qstg_pkg::STEP_W];
  assign new_entry.tone_on = in_item.tone_on;

  // Head of the queue, bypassed when it was written in the previous cycle.
  assign head = byp_r ? byp_data_r : rd_q_r;

  // Queue and player state update for one request.
  always_comb begin
    count_nxt   = count_r;
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    left_nxt    = left_r;
    total_nxt   = total_r;
    step_nxt    = step_r;
    tone_on_nxt = tone_on_r;
    phase_nxt   = phase_r;
    wr_en       = 1'b0;
    c_item_nxt  = '0;
    load        = (left_r == '0) && (count_r != '0);
    cur_left    = load ? head.len     : left_r;
    cur_total   = load ? head.len     : total_r;
    cur_step    = load ? head.step    : step_r;
    cur_on      = load ? head.tone_on : tone_on_r;
    cur_phase   = load ? '0           : phase_r;
    phase_sum   = cur_phase + cur_step;
    played      = (cur_total >= cur_left) ? cur_total - cur_left : '0;
    edge_dist   = (played < cur_left) ? played : cur_left;
    if (advance) begin
      unique case (qstg_pkg::req_t'(in_item.req))
        qstg_pkg::REQ_QUEUE: begin
          if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            c_item_nxt.dropped = 1'b1;
          end else begin
            wr_en      = 1'b1;
            wr_ptr_nxt = ptr_inc(wr_ptr_r);
            count_nxt  = count_r + 1'b1;
          end
        end
        qstg_pkg::REQ_STOP: begin
          count_nxt   = '0;
          wr_ptr_nxt  = '0;
          rd_ptr_nxt  = '0;
          left_nxt    = '0;
          total_nxt   = '0;
          tone_on_nxt = 1'b0;
          phase_nxt   = '0;
        end
        qstg_pkg::REQ_TICK: begin
          if (load) begin
            rd_ptr_nxt = ptr_inc(rd_ptr_r);
            count_nxt  = count_r - 1'b1;
          end
          total_nxt   = cur_total;
          step_nxt    = cur_step;
          tone_on_nxt = cur_on;
          phase_nxt   = cur_phase;
          left_nxt    = cur_left;
          if (cur_left != '0) begin
            c_item_nxt.playing = 1'b1;
            left_nxt = cur_left - 1'b1;
            if (cur_on) begin
              phase_nxt           = phase_sum;
              c_item_nxt.negative = phase_sum[qstg_pkg::PHASE_W-1];
              if (edge_dist < qstg_pkg::LEN_W'(qstg_pkg::RAMP_LEN)) begin
                c_item_nxt.ramp = qstg_pkg::RAMP_W'(edge_dist);
              end else begin
                c_item_nxt.ramp = qstg_pkg::RAMP_W'(qstg_pkg::RAMP_LEN);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Queue memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= new_entry;
    end
    rd_q_r     <= mem[rd_ptr_nxt];
    byp_r      <= wr_en && (wr_ptr_r == rd_ptr_nxt);
    byp_data_r <= new_entry;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      count_r   <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      left_r    <= '0;
      total_r   <= '0;
      step_r    <= '0;
      tone_on_r <= 1'b0;
      phase_r   <= '0;
    end else begin
      if (in_ready) begin
        c_valid_r <= in_valid;
      end
      count_r   <= count_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      left_r    <= left_nxt;
      total_r   <= total_nxt;
      step_r    <= step_nxt;
      tone_on_r <= tone_on_nxt;
      phase_r   <= phase_nxt;
    end
  end

  // Result payload toward the amplitude stage.
  always_ff @(posedge clk) begin
    if (advance) begin
      c_item_r <= c_item_nxt;
    end
  end

  assign out_valid = c_valid_r;
  assign out_item  = c_item_r;

endmodule

>>> rtl/qstg_shaper.sv
module qstg_shaper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qstg_pkg::shape_t              in_item,
  input  logic [qstg_pkg::PEAK_W-1:0]   peak,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qstg_pkg::SAMPLE_W-1:0] out_sample,
  output logic                          out_playing,
  output logic                          out_dropped
);

  logic                            d_valid_r;
  logic [qstg_pkg::SAMPLE_W-1:0]   sample_r;
  logic [qstg_pkg::SAMPLE_W-1:0]   sample_nxt;
  logic                            playing_r;
  logic                            dropped_r;
  logic [qstg_pkg::GAIN_W-1:0]     gain;
  logic [qstg_pkg::AMP_PROD_W-1:0] amp_prod;
  logic [qstg_pkg::SAMPLE_W-1:0]   amp;

  assign in_ready = !d_valid_r || out_ready;

  // Scale the peak by the ramp position and apply the square-wave sign.
  always_comb begin
    gain     = qstg_pkg::ramp_gain(in_item.ramp);
    amp_prod = qstg_pkg::AMP_PROD_W'(peak) * qstg_pkg::AMP_PROD_W'(gain);
    amp      = amp_prod[qstg_pkg::GAIN_SHIFT +: qstg_pkg::SAMPLE_W];
    sample_nxt = in_item.negative ? ('0 - amp) : amp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (in_ready) begin
      d_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sample_r  <= sample_nxt;
      playing_r <= in_item.playing;
      dropped_r <= in_item.dropped;
    end
  end

  assign out_valid   = d_valid_r;
  assign out_sample  = sample_r;
  assign out_playing = playing_r;
  assign out_dropped = dropped_r;

endmodule

>>> rtl/queued_square_tone_generator_core.sv
// Queued square-wave tone player.
// The input stream carries requests: in_tuser selects queue tone, stop all or
// sample tick, and in_tdata holds the tone frequency and duration for queue
// requests. Every request produces exactly one output transaction: on ticks
// out_tdata is the signed audio sample, otherwise zero; out_tuser flags a
// sounding tone and a queue request dropped because the queue was full.
// The peak amplitude is written through cfg_wr_en / cfg_wr_data only while the
// block is idle; the user must keep to this, the block does not enforce it.
// One request is accepted every cycle while the receiver does not stall: a
// four-register pipeline with the tone queue and player state updated in its
// third register stage.
// When the receiver stalls, the stages fill up and in_tready falls once all
// four registers hold transactions; no result is lost.
// Reset (synchronous, active low) empties the queue and the pipeline,
// silences the player and sets the peak amplitude to 3800. It needs no
// clearing pass.
module queued_square_tone_generator_core #(
  parameter int unsigned QUEUE_DEPTH = qstg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [15:0] tone_frequency, [31:16] tone_duration_ms
  input  logic [1:0]  in_tuser,     // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [15:0] sample_value
  output logic [1:0]  out_tuser,    // [0] tone_playing, [1] tone_dropped
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data   // peak_amplitude
);

  logic [qstg_pkg::PEAK_W-1:0] peak_r;
  logic                        prep_valid;
  logic                        prep_ready;
  qstg_pkg::prep_t             prep_item;
  logic                        shape_valid;
  logic                        shape_ready;
  qstg_pkg::shape_t            shape_item;

  // Peak amplitude register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= qstg_pkg::PEAK_RESET;
    end else if (cfg_wr_en) begin
      peak_r <= cfg_wr_data;
    end
  end

  qstg_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser),
    .in_freq   (in_tdata[15:0]),
    .in_dur    (in_tdata[31:16]),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_item  (prep_item)
  );

  qstg_player #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_player (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_item   (prep_item),
    .out_valid (shape_valid),
    .out_ready (shape_ready),
    .out_item  (shape_item)
  );

  qstg_shaper u_shaper (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (shape_valid),
    .in_ready    (shape_ready),
    .in_item     (shape_item),
    .peak        (peak_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_sample  (out_tdata),
    .out_playing (out_tuser[0]),
    .out_dropped (out_tuser[1])
  );

  // A nonzero sample only comes from a sounding tone.
  a_sample_needs_tone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata != '0)) |-> out_tuser[0])
    else $error("nonzero sample without a sounding tone");

  // A request is either a dropped queue request or a tick, never both.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("playing and dropped flags set together");

  // The scaled magnitude never reaches the most negative code.
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata != 16'h8000))
    else $error("sample magnitude out of range");

endmodule
